@@ hw/rtl/rph_pkg.sv @@
// shared constants, types and codes of the rgb parade histogram
package rph_pkg;

    // scope store geometry
    localparam int MAX_ROWS = 1024;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int NUM_CH   = 3;

    // field widths
    localparam int ROW_W    = 10;
    localparam int CH_W     = 8;
    localparam int LVL_W    = 8;
    localparam int CNT_W    = 11;
    localparam int ROWS_W   = 11;
    localparam int STEP_W   = 16;
    localparam int STEP_FRAC = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [LVL_W-1:0] LVL_MAX = '1;

    // product of a byte and a row index, as fed to the divide by 255
    localparam int PROD_W   = CH_W + ADDR_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP  = 1'd1;

    localparam logic [ROWS_W-1:0] ROWS_RST = 11'd256;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd4096;

    // transaction kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // classified work for the back end
    typedef struct packed {
        logic                           kind;
        logic [NUM_CH-1:0][ADDR_W-1:0]  addr;
        logic [ROW_W-1:0]               row;
        logic                           row_ok;
    } t_work;

    // queue status seen by the top and the back end
    typedef struct packed {
        logic              vld;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

@@ hw/rtl/rph_front.sv @@
// front end: takes transactions, maps pixel bytes to scope rows
module rph_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic                      i_kind,
    input  logic [rph_pkg::CH_W-1:0]  i_red,
    input  logic [rph_pkg::CH_W-1:0]  i_green,
    input  logic [rph_pkg::CH_W-1:0]  i_blue,
    input  logic [rph_pkg::ROW_W-1:0] i_row,
    input  logic [rph_pkg::ROWS_W-1:0] i_rows_in_use,
    output logic                      o_push,
    output rph_pkg::t_work            o_work
);
    import rph_pkg::*;

    // exact floor(x / 255): estimate by x*257 >> 16, then one correction
    function automatic logic [PROD_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W+8:0] xw;
        logic [PROD_W+8:0] rem;
        logic [PROD_W-1:0] q;
        xw  = (PROD_W+9)'(x);
        q   = PROD_W'((xw + (xw << 8)) >> 16);
        rem = xw - ((PROD_W+9)'(q) << 8) + (PROD_W+9)'(q);
        if (rem >= (PROD_W+9)'(255)) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    logic [ADDR_W-1:0]               top;
    logic [NUM_CH-1:0][CH_W-1:0]     val;
    logic                            r_f1_vld;
    logic                            r_f1_kind;
    logic [ROW_W-1:0]                r_f1_row;
    logic [ADDR_W-1:0]               r_f1_top;
    logic [NUM_CH-1:0][PROD_W-1:0]   r_f1_prod;

    // top row index from the rows in use, clamped to the store
    always_comb begin
        if (i_rows_in_use == '0) begin
            top = '0;
        end else if (32'(i_rows_in_use) > 32'(MAX_ROWS)) begin
            top = ADDR_W'(MAX_ROWS - 1);
        end else begin
            top = ADDR_W'(i_rows_in_use - 1'b1);
        end
    end

    assign val = {i_blue, i_green, i_red};

    // first stage: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= i_take;
        end
    end

    // first stage: byte times top row
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_f1_kind <= i_kind;
            r_f1_row  <= i_row;
            r_f1_top  <= top;
            for (int c = 0; c < NUM_CH; c++) begin
                r_f1_prod[c] <= PROD_W'(val[c]) * PROD_W'(top);
            end
        end
    end

    // second stage: row of each channel, or the row to read
    always_comb begin
        o_push        = r_f1_vld;
        o_work.kind   = r_f1_kind;
        o_work.row    = r_f1_row;
        o_work.row_ok = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            o_work.addr[c] = r_f1_top - ADDR_W'(div255(r_f1_prod[c]));
        end
        if (r_f1_kind == KIND_READ) begin
            o_work.row_ok = (32'(r_f1_row) < 32'(MAX_ROWS));
            for (int c = 0; c < NUM_CH; c++) begin
                o_work.addr[c] = ADDR_W'(r_f1_row);
            end
        end
    end

endmodule

@@ hw/rtl/rph_queue.sv @@
// short queue of classified work between front and back
module rph_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rph_pkg::t_work     i_work,
    output rph_pkg::t_q_status o_status,
    output rph_pkg::t_work     o_work
);
    import rph_pkg::*;

    t_work             r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    // back end never stalls, so the head leaves whenever present
    assign pop = (r_count != '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_status.vld   = pop;
    assign o_status.count = r_count;
    assign o_work         = r_mem[r_rd_ptr];

endmodule

@@ hw/rtl/rph_back.sv @@
// back end: count stores, read-modify-write with forwarding, level output
module rph_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  rph_pkg::t_work             i_work,
    input  logic [rph_pkg::STEP_W-1:0] i_level_step,
    output logic                       o_clr_busy,
    output logic                       o_valid,
    output logic [rph_pkg::ROW_W-1:0]  o_row_out,
    output logic [rph_pkg::LVL_W-1:0]  o_red_level,
    output logic [rph_pkg::LVL_W-1:0]  o_green_level,
    output logic [rph_pkg::LVL_W-1:0]  o_blue_level
);
    import rph_pkg::*;

    localparam int MUL_W = CNT_W + STEP_W;

    logic                           r_clr_busy;
    logic [ADDR_W-1:0]              r_clr_addr;
    logic                           r_w_vld;
    t_work                          r_w_work;
    logic [NUM_CH-1:0][CNT_W-1:0]   r_rd;
    logic [NUM_CH-1:0]              r_fwd_vld;
    logic [NUM_CH-1:0][ADDR_W-1:0]  r_fwd_addr;
    logic [NUM_CH-1:0][CNT_W-1:0]   r_fwd_data;
    logic                           r_out_vld;
    logic [ROW_W-1:0]               r_out_row;
    logic [NUM_CH-1:0][LVL_W-1:0]   r_out_lvl;

    logic [NUM_CH-1:0]              we;
    logic [NUM_CH-1:0][ADDR_W-1:0]  wa;
    logic [NUM_CH-1:0][CNT_W-1:0]   wd;
    logic [NUM_CH-1:0][CNT_W-1:0]   cur;
    logic [NUM_CH-1:0][LVL_W-1:0]   lvl;
    logic [NUM_CH-1:0][MUL_W-1:0]   prod;
    logic [NUM_CH-1:0][MUL_W-1:0]   scaled;

    // clearing sweep after reset, one row a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MAX_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // read stage: address goes to the stores, transaction moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else begin
            r_w_vld <= i_vld && !r_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_work <= i_work;
    end

    // one count store per channel
    for (genvar g = 0; g < NUM_CH; g++) begin : g_store
        logic [CNT_W-1:0] mem [MAX_ROWS];

        always_ff @(posedge i_clk) begin
            r_rd[g] <= mem[i_work.addr[g]];
            if (we[g]) begin
                mem[wa[g]] <= wd[g];
            end
        end
    end

    // modify stage: forward the previous write, bump or clear, scale
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_fwd_vld[c] && (r_fwd_addr[c] == r_w_work.addr[c])) begin
                cur[c] = r_fwd_data[c];
            end else begin
                cur[c] = r_rd[c];
            end
            prod[c]   = MUL_W'(cur[c]) * MUL_W'(i_level_step);
            scaled[c] = prod[c] >> STEP_FRAC;
            if (scaled[c] > MUL_W'(LVL_MAX)) begin
                lvl[c] = LVL_MAX;
            end else begin
                lvl[c] = LVL_W'(scaled[c]);
            end
            wa[c] = r_w_work.addr[c];
            if (r_w_work.kind == KIND_PIXEL) begin
                we[c] = r_w_vld;
                wd[c] = (cur[c] == CNT_MAX) ? cur[c] : cur[c] + 1'b1;
            end else begin
                we[c] = r_w_vld && r_w_work.row_ok;
                wd[c] = '0;
            end
            if (r_clr_busy) begin
                we[c] = 1'b1;
                wa[c] = r_clr_addr;
                wd[c] = '0;
            end
        end
    end

    // last write per channel, for the following transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= '0;
        end else begin
            r_fwd_vld <= we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= wa;
        r_fwd_data <= wd;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_w_vld && (r_w_work.kind == KIND_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= r_w_work.row;
        r_out_lvl <= r_w_work.row_ok ? lvl : '0;
    end

    assign o_clr_busy    = r_clr_busy;
    assign o_valid       = r_out_vld;
    assign o_row_out     = r_out_row;
    assign o_red_level   = r_out_lvl[0];
    assign o_green_level = r_out_lvl[1];
    assign o_blue_level  = r_out_lvl[2];

endmodule

@@ hw/rtl/rgb_parade_histogram_unit.sv @@
// top level of the rgb parade histogram: config registers, front, queue, back
//
// One scope column of an RGB parade. A pixel transaction (kind 0) adds one hit
// to the row of each of its red, green and blue bytes; a read transaction
// (kind 1) returns the three saturated levels of one row on o_valid and clears
// that row. A transaction is taken when start is high and busy is low; the
// block takes one every cycle while busy is low. A read result appears on
// o_valid after the front's first stage, the queue, the back end's read stage
// and its result register, exactly one cycle wide. Results cannot be held
// off. Each channel's count store has separate read and write ports, and the
// last write is forwarded to the following transaction, so one transaction a
// cycle can pass. After reset, busy stays high while the count stores are
// swept to zero, row by row; configuration writes are taken during that time.
// Change rows_in_use and level_step only while no transaction is under way.
module rgb_parade_histogram_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [rph_pkg::CH_W-1:0]      i_red,
    input  logic [rph_pkg::CH_W-1:0]      i_green,
    input  logic [rph_pkg::CH_W-1:0]      i_blue,
    input  logic [rph_pkg::ROW_W-1:0]     i_row,
    input  logic                          i_cfg_we,
    input  logic [rph_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rph_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [rph_pkg::ROW_W-1:0]     o_row_out,
    output logic [rph_pkg::LVL_W-1:0]     o_red_level,
    output logic [rph_pkg::LVL_W-1:0]     o_green_level,
    output logic [rph_pkg::LVL_W-1:0]     o_blue_level
);
    import rph_pkg::*;

    logic [ROWS_W-1:0] r_rows_in_use;
    logic [STEP_W-1:0] r_level_step;
    logic              take;
    logic              push;
    logic              clr_busy;
    t_work             front_work;
    t_work             head_work;
    t_q_status         q_status;
    logic              f1_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RST;
            r_level_step  <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data[ROWS_W-1:0];
                CFG_LEVEL_STEP:  r_level_step  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // hold off while sweeping or when the queue could run out of room
    assign f1_vld = push;
    assign busy   = clr_busy ||
                    ((32'(q_status.count) + 32'(f1_vld)) >= 32'(Q_DEPTH));
    assign take   = start && !busy;

    rph_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_kind        (i_kind),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_row         (i_row),
        .i_rows_in_use (r_rows_in_use),
        .o_push        (push),
        .o_work        (front_work)
    );

    rph_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (front_work),
        .o_status (q_status),
        .o_work   (head_work)
    );

    rph_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (q_status.vld),
        .i_work        (head_work),
        .i_level_step  (r_level_step),
        .o_clr_busy    (clr_busy),
        .o_valid       (o_valid),
        .o_row_out     (o_row_out),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level)
    );

    // every transaction leaves after a fixed latency, a result only for reads
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##4 (o_valid == $past(i_kind, 4)))
        else $error("result strobe does not follow the taken transaction");

    // the row reported is the row that was asked for
    a_row_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_out == $past(i_row, 4)))
        else $error("reported row differs from requested row");

    // no transaction reaches the queue or the back end while the stores are being swept
    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (!push && !q_status.vld))
        else $error("transaction in flight during store sweep");

endmodule
